// File: src/tnp_pkg.sv
// Shared types and constants for the telemetry nibble packer.
`default_nettype none
package tnp_pkg;

  localparam int unsigned CAP_W    = 16;
  localparam int unsigned QDEPTH   = 3;
  localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

  // Header bytes and nibble codes
  localparam logic [7:0] HDR_M     = 8'hA1;
  localparam logic [7:0] HDR_G     = 8'hA2;
  localparam logic [7:0] HDR_T     = 8'hA3;
  localparam logic [3:0] NIB_COLON = 4'hB;
  localparam logic [3:0] NIB_ZERO  = 4'hC;
  localparam logic [3:0] NIB_DOT   = 4'hD;
  localparam logic [3:0] NIB_MINUS = 4'hE;
  localparam logic [3:0] NIB_COMMA = 4'hF;
  localparam logic [3:0] NIB_PAD   = 4'hA;

  // Character codes
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
    logic       ovf;
  } rslt_t;

endpackage
`default_nettype wire

// File: src/telemetry_nibble_packer_core.sv
// Telemetry nibble packer: character stream in, packed byte stream out.
`default_nettype none
// Takes one character per cycle and packs it into bytes in the same cycle it is
// accepted; results wait in a three-word output queue. A character gives zero,
// one or two words. The input is stalled while the queue holds two or more
// words, so a character that gives two words (a header after a lone nibble)
// holds off the next character; otherwise the block sustains one character per
// cycle while the output is not stalled. An accepted character's words are
// registered into the queue behind any waiting words. The capacity register may
// be written at any time and applies to the next character accepted.
module telemetry_nibble_packer_core import tnp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             last_result,
  output logic             overflow
);

  logic [CAP_W-1:0]    out_capacity;
  logic                nibble_pending, nibble_pending_next;
  logic [3:0]          high_nibble, high_nibble_next;
  logic [CAP_W-1:0]    bytes_emitted, bytes_emitted_next;
  logic                dropped_flag, dropped_flag_next;
  rslt_t               q [QDEPTH];
  rslt_t               q_next [QDEPTH];
  logic [QCOUNT_W-1:0] q_count, q_count_next;

  logic push, pop;

  assign in_stall    = (q_count > QCOUNT_W'(1));
  assign out_valid   = (q_count != '0);
  assign push        = in_valid && !in_stall;
  assign pop         = out_valid && !out_stall;
  assign out_byte    = q[0].data;
  assign byte_valid  = q[0].has_byte;
  assign last_result = q[0].is_last;
  assign overflow    = q[0].ovf;

  always_comb begin
    logic             is_hdr, is_nib;
    logic [7:0]       hdr;
    logic [3:0]       nib;
    logic             p0, p1, e0, e1;
    logic [7:0]       c0, c1;
    logic [CAP_W-1:0] cnt1;
    logic             drop_any;
    rslt_t            r0, r1;
    logic [1:0]       n_push;
    logic [QCOUNT_W-1:0] base;

    is_hdr = 1'b0;
    is_nib = 1'b0;
    hdr    = '0;
    nib    = '0;
    case (char_code) inside
      CH_M:             begin is_hdr = 1'b1; hdr = HDR_M; end
      CH_G:             begin is_hdr = 1'b1; hdr = HDR_G; end
      CH_T:             begin is_hdr = 1'b1; hdr = HDR_T; end
      CH_COLON:         begin is_nib = 1'b1; nib = NIB_COLON; end
      CH_ZERO:          begin is_nib = 1'b1; nib = NIB_ZERO; end
      CH_DOT:           begin is_nib = 1'b1; nib = NIB_DOT; end
      CH_MINUS:         begin is_nib = 1'b1; nib = NIB_MINUS; end
      CH_COMMA:         begin is_nib = 1'b1; nib = NIB_COMMA; end
      [CH_ONE:CH_NINE]: begin is_nib = 1'b1; nib = char_code[3:0]; end
      default:          ;
    endcase

    // Candidate bytes in output order; p1 only ever follows p0
    p0 = 1'b0;
    p1 = 1'b0;
    c0 = '0;
    c1 = '0;
    nibble_pending_next = nibble_pending;
    high_nibble_next    = high_nibble;
    if (is_hdr) begin
      nibble_pending_next = 1'b0;
      high_nibble_next    = '0;
      if (nibble_pending) begin
        p0 = 1'b1;
        c0 = {high_nibble, NIB_PAD};
        p1 = 1'b1;
        c1 = hdr;
      end else begin
        p0 = 1'b1;
        c0 = hdr;
      end
    end else if (is_nib) begin
      if (nibble_pending) begin
        p0 = 1'b1;
        c0 = {high_nibble, nib};
        nibble_pending_next = 1'b0;
        high_nibble_next    = '0;
      end else if (last_char) begin
        p0 = 1'b1;
        c0 = {nib, NIB_PAD};
      end else begin
        nibble_pending_next = 1'b1;
        high_nibble_next    = nib;
      end
    end else if (last_char && nibble_pending) begin
      p0 = 1'b1;
      c0 = {high_nibble, NIB_PAD};
    end

    // Capacity check per byte; drop the rest
    e0   = p0 && (bytes_emitted < out_capacity);
    cnt1 = bytes_emitted + CAP_W'(e0);
    e1   = p1 && (cnt1 < out_capacity);
    bytes_emitted_next = cnt1 + CAP_W'(e1);
    drop_any           = (p0 && !e0) || (p1 && !e1);
    dropped_flag_next  = dropped_flag || drop_any;

    r0 = '{data: c0, has_byte: e0, is_last: 1'b0, ovf: 1'b0};
    r1 = '{data: c1, has_byte: 1'b1, is_last: 1'b0, ovf: 1'b0};
    if (!e0) begin
      r0.data = '0;
    end
    n_push = {1'b0, e0} + {1'b0, e1};
    if (last_char) begin
      if (e1) begin
        r1.is_last = 1'b1;
        r1.ovf     = dropped_flag_next;
      end else begin
        r0.is_last = 1'b1;
        r0.ovf     = dropped_flag_next;
        n_push     = 2'd1;
      end
      nibble_pending_next = 1'b0;
      high_nibble_next    = '0;
      bytes_emitted_next  = '0;
      dropped_flag_next   = 1'b0;
    end

    // Queue: shift on pop, append on push
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    base = q_count;
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
      base = q_count - QCOUNT_W'(1);
    end
    q_count_next = base;
    if (push) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if ((n_push != 2'd0) && (QCOUNT_W'(i) == base)) begin
          q_next[i] = r0;
        end
        if ((n_push == 2'd2) && (QCOUNT_W'(i) == base + QCOUNT_W'(1))) begin
          q_next[i] = r1;
        end
      end
      q_count_next = base + QCOUNT_W'(n_push);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity   <= '1;
      nibble_pending <= 1'b0;
      high_nibble    <= '0;
      bytes_emitted  <= '0;
      dropped_flag   <= 1'b0;
      q_count        <= '0;
    end else begin
      if (cfg_wr_en) begin
        out_capacity <= cfg_wr_data;
      end
      if (push) begin
        nibble_pending <= nibble_pending_next;
        high_nibble    <= high_nibble_next;
        bytes_emitted  <= bytes_emitted_next;
        dropped_flag   <= dropped_flag_next;
      end
      q_count <= q_count_next;
    end
  end

  // Queue payload needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule
`default_nettype wire

// File: src/tnp_checker.sv
// Port-level checks for the telemetry nibble packer, bound to the top level.
`default_nettype none
module tnp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last_result,
  input logic       overflow
);

  // A stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word withdrawn while stalled");

  // An empty word only ever closes a string
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_result && (out_byte == 8'h00))
    else $error("empty word not marked last or not zero");

  // Overflow is reported on the closing word alone
  a_ovf_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last_result)
    else $error("overflow flagged on a non-final word");

  // Reset empties the output queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind telemetry_nibble_packer_core tnp_checker u_tnp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .byte_valid  (byte_valid),
  .last_result (last_result),
  .overflow    (overflow)
);
`default_nettype wire

// File: sim/tnp_word_checker.sv
// Watches both channels of the nibble packer, predicts each packed word and compares it.
`timescale 1ns / 100ps
module tnp_word_checker import tnp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [7:0]       out_byte,
  input  logic             byte_valid,
  input  logic             last_result,
  input  logic             overflow,
  output int unsigned      mismatches,
  output int unsigned      words_checked,
  output int unsigned      words_waiting
);

  localparam int unsigned SHOWN_MAX = 10;

  rslt_t            predicted_words[$];
  logic [CAP_W-1:0] capacity;
  logic             have_high;
  logic [3:0]       high_nib;
  logic [CAP_W-1:0] emitted;
  logic             dropped;

  function automatic void clear_string();
    have_high = 1'b0;
    high_nib  = '0;
    emitted   = '0;
    dropped   = 1'b0;
  endfunction

  // Emit only below the capacity; otherwise drop and remember it.
  function automatic void emit_byte(input logic [7:0] b);
    rslt_t w;
    if (emitted < capacity) begin
      w.data     = b;
      w.has_byte = 1'b1;
      w.is_last  = 1'b0;
      w.ovf      = 1'b0;
      predicted_words.push_back(w);
      emitted = emitted + 1'b1;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void flush_high();
    if (have_high) begin
      emit_byte({high_nib, NIB_PAD});
      have_high = 1'b0;
      high_nib  = '0;
    end
  endfunction

  function automatic void pack_char(input logic [7:0] c, input logic fin);
    int unsigned n_start;
    logic [7:0]  hdr;
    logic [3:0]  nib;
    logic        is_nib;
    rslt_t       w;
    n_start = predicted_words.size();
    hdr     = '0;
    nib     = '0;
    is_nib  = 1'b0;
    case (c)
      CH_M:     hdr = HDR_M;
      CH_G:     hdr = HDR_G;
      CH_T:     hdr = HDR_T;
      CH_COLON: begin nib = NIB_COLON; is_nib = 1'b1; end
      CH_ZERO:  begin nib = NIB_ZERO;  is_nib = 1'b1; end
      CH_DOT:   begin nib = NIB_DOT;   is_nib = 1'b1; end
      CH_MINUS: begin nib = NIB_MINUS; is_nib = 1'b1; end
      CH_COMMA: begin nib = NIB_COMMA; is_nib = 1'b1; end
      default: begin
        if (c >= CH_ONE && c <= CH_NINE) begin
          nib    = c[3:0];
          is_nib = 1'b1;
        end
      end
    endcase

    if (hdr != '0) begin
      flush_high();
      emit_byte(hdr);
    end else if (is_nib) begin
      if (!have_high) begin
        high_nib  = nib;
        have_high = 1'b1;
      end else begin
        emit_byte({high_nib, nib});
        have_high = 1'b0;
        high_nib  = '0;
      end
    end

    if (fin) begin
      flush_high();
      // No byte from this character: an empty word carries the end marker.
      if (predicted_words.size() == n_start) begin
        w = '0;
        predicted_words.push_back(w);
      end
      w         = predicted_words.pop_back();
      w.is_last = 1'b1;
      w.ovf     = dropped;
      predicted_words.push_back(w);
      clear_string();
    end
  endfunction

  function automatic void note_mismatch(input string what, input rslt_t want, input rslt_t got);
    mismatches++;
    if (mismatches <= SHOWN_MAX)
      $display("%0t: %s: expected byte %h valid %b last %b ovf %b,",
               $time, what, want.data, want.has_byte, want.is_last, want.ovf,
               " got byte %h valid %b last %b ovf %b",
               got.data, got.has_byte, got.is_last, got.ovf);
  endfunction

  always @(posedge clk) begin
    rslt_t got;
    rslt_t want;
    if (rst) begin
      capacity = '1;
      clear_string();
      predicted_words.delete();
      mismatches    = 0;
      words_checked = 0;
    end else begin
      if (cfg_wr_en)
        capacity = cfg_wr_data;
      // Compare before predicting, so a word can never match its own character early.
      if (out_valid && !out_stall) begin
        got.data     = out_byte;
        got.has_byte = byte_valid;
        got.is_last  = last_result;
        got.ovf      = overflow;
        if (predicted_words.size() == 0) begin
          want = '0;
          note_mismatch("unexpected word", want, got);
        end else begin
          want = predicted_words.pop_front();
          words_checked++;
          if (got.data !== want.data || got.has_byte !== want.has_byte ||
              got.is_last !== want.is_last || got.ovf !== want.ovf)
            note_mismatch("word mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        pack_char(char_code, last_char);
    end
    words_waiting = predicted_words.size();
  end

endmodule

// File: sim/telemetry_nibble_packer_core_tb.sv
// Testbench top for the telemetry nibble packer: stimulus, capacity phases and verdict.
`timescale 1ns / 100ps
module telemetry_nibble_packer_core_tb;
  import tnp_pkg::*;

  localparam int unsigned RUN_LIMIT     = 200000;
  localparam int unsigned IDLE_PCT      = 23;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RANDOM_CHARS  = 750;
  localparam int unsigned PHASE_CHARS   = 125;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic [7:0]       char_code   = '0;
  logic             last_char   = 1'b0;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             last_result;
  logic             overflow;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned words_waiting;
  int unsigned cycles       = 0;
  int unsigned chars_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned cap_settings = 0;
  logic        steady       = 1'b0;

  telemetry_nibble_packer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_result (last_result),
    .overflow    (overflow)
  );

  tnp_word_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_result   (last_result),
    .overflow      (overflow),
    .mismatches    (mismatches),
    .words_checked (words_checked),
    .words_waiting (words_waiting)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding", cycles, words_waiting);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold the character until it is taken; idle now and then before offering it.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic send_text(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_settings++;
  endtask

  // Mostly telemetry characters, with stray bytes mixed in; a noisy call gives random bytes only.
  function automatic logic [7:0] telemetry_char(input bit noisy);
    string alphabet = "0123456789:.-,MGT";
    if (noisy || $urandom_range(0, 99) < 15)
      return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  initial begin
    logic [CAP_W-1:0] caps[6];
    int unsigned      len;
    int unsigned      phase;
    bit               noisy;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes of the code, every punctuation nibble, headers with and without a lone nibble,
    // and an end marker on a skipped character.
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("1:0.-,9MGT", 1'b0);
    send_char("x", 1'b1);
    send_text("3T", 1'b1);
    send_text("5", 1'b1);

    // Lower the capacity in the middle of a string.
    send_text("24680", 1'b0);
    set_capacity(16'd2);
    send_text("7", 1'b1);

    // Capacity zero drops everything.
    set_capacity(16'd0);
    send_text("M1", 1'b1);

    caps[0] = 16'hFFFF;
    caps[1] = 16'd1;
    caps[2] = 16'd0;
    caps[3] = 16'd3;
    caps[4] = 16'($urandom_range(0, 12));
    caps[5] = 16'($urandom_range(2, 65534));

    phase = 0;
    set_capacity(caps[0]);
    while (chars_sent < RANDOM_CHARS + 25) begin
      if (chars_sent >= 25 + (phase + 1) * PHASE_CHARS && phase < 5) begin
        phase++;
        set_capacity(caps[phase]);
        // One phase runs with no idling on either side.
        steady = (phase == 3);
      end
      len   = $urandom_range(1, 24);
      noisy = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++)
        send_char(telemetry_char(noisy), i == len - 1);
    end
    steady = 1'b0;

    wait_drained();
    $display("Sent %0d characters in %0d strings across %0d capacity settings.",
             chars_sent, strings_sent, cap_settings);
    $display("Checked %0d packed words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && words_waiting == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
